// ----- src/jps_pkg.sv -----
// ----------------------------------------------------------------------------
// jps_pkg: shared types, constants and helpers
// Fixed-point formats, controller/datapath command codes and rounding helper
// for the Jacobi polynomial sequence unit.
// ----------------------------------------------------------------------------
package jps_pkg;

  localparam int MAX_ORDER     = 64;
  localparam int OUT_FRAC_BITS = 24;
  localparam int DEG_W         = $clog2(MAX_ORDER);
  localparam int CNT_W         = 7;
  localparam int CFG_W         = 31;
  localparam int CFG_IDX_W     = 2;
  localparam int P1_SH         = 55 - OUT_FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BETA  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV = 2'd2;

  typedef logic signed [63:0]  s64_t;
  typedef logic signed [127:0] s128_t;

  localparam s64_t ONE_Q24  = 64'sh0000_0000_0100_0000;
  localparam s64_t TWO_Q24  = 64'sh0000_0000_0200_0000;
  localparam s64_t ONE_Q30  = 64'sh0000_0000_4000_0000;
  localparam s64_t TWO_Q30  = 64'sh0000_0000_8000_0000;
  localparam s64_t S64_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam s64_t S64_MIN  = 64'sh8000_0000_0000_0000;
  localparam s64_t Q0_VAL   = s64_t'(64'sd1 <<< OUT_FRAC_BITS);

  // datapath operation codes
  typedef logic [4:0] op_t;
  localparam op_t OP_AA     = 5'd0;
  localparam op_t OP_BB     = 5'd1;
  localparam op_t OP_P1A    = 5'd2;
  localparam op_t OP_P1B    = 5'd3;
  localparam op_t OP_P1C    = 5'd4;
  localparam op_t OP_T1     = 5'd5;
  localparam op_t OP_T2     = 5'd6;
  localparam op_t OP_F1     = 5'd7;
  localparam op_t OP_T3     = 5'd8;
  localparam op_t OP_F2     = 5'd9;
  localparam op_t OP_D1     = 5'd10;
  localparam op_t OP_D2     = 5'd11;
  localparam op_t OP_N1     = 5'd12;
  localparam op_t OP_N2     = 5'd13;
  localparam op_t OP_DIV    = 5'd14;
  localparam op_t OP_Q0     = 5'd15;
  localparam op_t OP_DV     = 5'd16;
  localparam op_t OP_EMIT_Z = 5'd17;
  localparam op_t OP_EMIT_Q = 5'd18;
  localparam op_t OP_EMIT_D = 5'd19;
  localparam op_t OP_INC    = 5'd20;

  typedef struct packed {
    logic load;
    logic start;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic deriv;
    logic cnt_zero;
    logic cnt_one;
    logic k_last;
    logic k_zero;
  } dp_sts_t;

  // round half up, arithmetic shift right, clip to 64 bits; bit 64 flags a clip
  function automatic logic [64:0] shr_rnd_sat(input s128_t v, input int sh);
    s128_t t;
    s128_t q;
    logic  sat;
    s64_t  r;
    t   = v + (s128_t'(1) <<< (sh - 1));
    q   = t >>> sh;
    sat = (q[127:63] != {65{q[63]}});
    if (sat) begin
      r = t[127] ? S64_MIN : S64_MAX;
    end else begin
      r = q[63:0];
    end
    return {sat, r};
  endfunction

endpackage

// ----- src/jps_in_if.sv -----
// ----------------------------------------------------------------------------
// jps_in_if: input channel
// Evaluation point and degree count with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface jps_in_if import jps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic signed [31:0] point_q30;
  logic [CNT_W-1:0]  degree_count;

  modport source (output valid, point_q30, degree_count, input ready);
  modport sink   (input valid, point_q30, degree_count, output ready);
endinterface

// ----- src/jps_out_if.sv -----
// ----------------------------------------------------------------------------
// jps_out_if: result channel
// One polynomial or derivative value per transfer, with degree and flags.
// ----------------------------------------------------------------------------
interface jps_out_if import jps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DEG_W-1:0] degree;
  logic signed [63:0] value_q24;
  logic             saturated;
  logic             last;

  modport source (output valid, degree, value_q24, saturated, last, input ready);
  modport sink   (input valid, degree, value_q24, saturated, last, output ready);
endinterface

// ----- src/jps_mul.sv -----
// ----------------------------------------------------------------------------
// jps_mul: sequential 64x64 signed multiplier
// Four 32x32 partial products on magnitudes, accumulated over cycles, then
// sign applied. Full 128-bit result, done pulses one cycle.
// ----------------------------------------------------------------------------
module jps_mul import jps_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  s64_t  a,
  input  s64_t  b,
  output logic  done,
  output s128_t prod
);

  logic         busy_r;
  logic [2:0]   step_r;
  logic         done_r;
  logic         neg_r;
  logic [63:0]  ua_r;
  logic [63:0]  ub_r;
  logic [63:0]  pp_r;
  logic [1:0]   sel_r;
  logic [127:0] acc_r;
  s128_t        prod_r;

  logic [31:0]  op1;
  logic [31:0]  op2;
  logic [63:0]  pp_nxt;
  logic [127:0] pp_shift;

  always_comb begin
    case (step_r[1:0])
      2'd0: begin op1 = ua_r[31:0];  op2 = ub_r[31:0];  end
      2'd1: begin op1 = ua_r[31:0];  op2 = ub_r[63:32]; end
      2'd2: begin op1 = ua_r[63:32]; op2 = ub_r[31:0];  end
      default: begin op1 = ua_r[63:32]; op2 = ub_r[63:32]; end
    endcase
    pp_nxt = op1 * op2;
    case (sel_r)
      2'd0: pp_shift = {64'd0, pp_r};
      2'd1, 2'd2: pp_shift = {32'd0, pp_r, 32'd0};
      default: pp_shift = {pp_r, 64'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 3'd0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ua_r  <= a[63] ? 64'(-a) : 64'(a);
      ub_r  <= b[63] ? 64'(-b) : 64'(b);
      neg_r <= a[63] ^ b[63];
      acc_r <= '0;
    end else if (busy_r) begin
      if (step_r < 3'd4) begin
        pp_r  <= pp_nxt;
        sel_r <= step_r[1:0];
      end
      if (step_r >= 3'd1 && step_r <= 3'd4) begin
        acc_r <= acc_r + pp_shift;
      end
      if (step_r == 3'd5) begin
        prod_r <= neg_r ? s128_t'(-acc_r) : s128_t'(acc_r);
      end
    end
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

// ----- src/jps_div.sv -----
// ----------------------------------------------------------------------------
// jps_div: iterative 128/64 signed divider
// Restoring division on magnitudes, two quotient bits per cycle, quotient
// rounded half away from zero and clipped to 64 bits.
// ----------------------------------------------------------------------------
module jps_div import jps_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  s128_t num,
  input  s64_t  den,
  output logic  done,
  output s64_t  quo,
  output logic  sat
);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_RND  = 2'd2;
  localparam logic [1:0] D_OUT  = 2'd3;

  logic [1:0]   st_r;
  logic [5:0]   cnt_r;
  logic         done_r;
  logic [127:0] un_r;
  logic [63:0]  r_r;
  logic [63:0]  ud_r;
  logic         neg_r;
  logic         nneg_r;
  logic         zden_r;
  logic         nzero_r;
  s64_t         quo_r;
  logic         sat_r;

  logic [64:0]  r1;
  logic [64:0]  r2;
  logic         ge1;
  logic         ge2;
  logic [63:0]  r1s;
  logic [63:0]  r2s;
  logic         over;

  always_comb begin
    r1  = {r_r, un_r[127]};
    ge1 = (r1 >= {1'b0, ud_r});
    r1s = ge1 ? 64'(r1 - {1'b0, ud_r}) : r1[63:0];
    r2  = {r1s, un_r[126]};
    ge2 = (r2 >= {1'b0, ud_r});
    r2s = ge2 ? 64'(r2 - {1'b0, ud_r}) : r2[63:0];
    over = (un_r[127:64] != 64'd0) ||
           (neg_r ? (un_r[63:0] > 64'h8000_0000_0000_0000) : un_r[63]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        D_IDLE: begin
          if (start) begin
            cnt_r <= 6'd0;
            st_r  <= (den == 64'sd0) ? D_OUT : D_RUN;
          end
        end
        D_RUN: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            st_r <= D_RND;
          end
        end
        D_RND: st_r <= D_OUT;
        D_OUT: begin
          done_r <= 1'b1;
          st_r   <= D_IDLE;
        end
        default: st_r <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      D_IDLE: begin
        if (start) begin
          un_r    <= num[127] ? 128'(-num) : 128'(num);
          ud_r    <= den[63] ? 64'(-den) : 64'(den);
          r_r     <= 64'd0;
          nneg_r  <= num[127];
          neg_r   <= num[127] ^ den[63];
          zden_r  <= (den == 64'sd0);
          nzero_r <= (num == 128'sd0);
        end
      end
      D_RUN: begin
        r_r  <= r2s;
        un_r <= {un_r[125:0], ge1, ge2};
      end
      D_RND: begin
        un_r <= un_r + 128'(r_r >= (ud_r - r_r));
      end
      D_OUT: begin
        if (zden_r) begin
          sat_r <= 1'b1;
          quo_r <= nzero_r ? 64'sd0 : (nneg_r ? S64_MIN : S64_MAX);
        end else if (over) begin
          sat_r <= 1'b1;
          quo_r <= neg_r ? S64_MIN : S64_MAX;
        end else begin
          sat_r <= 1'b0;
          quo_r <= neg_r ? s64_t'(-un_r[63:0]) : s64_t'(un_r[63:0]);
        end
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign sat  = sat_r;

endmodule

// ----- src/jps_datapath.sv -----
// ----------------------------------------------------------------------------
// jps_datapath: recurrence datapath
// Configuration registers, run registers, shared multiplier, divider,
// operand selection, writeback and the result output register.
// ----------------------------------------------------------------------------
module jps_datapath import jps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic signed [31:0]   in_point,
  input  logic [CNT_W-1:0]     in_count,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DEG_W-1:0]     out_degree,
  output s64_t                 out_value,
  output logic                 out_saturated,
  output logic                 out_last
);

  logic signed [CFG_W-1:0] alpha_r;
  logic signed [CFG_W-1:0] beta_r;
  logic                    deriv_cfg_r;

  logic             busy_r;
  op_t              op_r;
  logic             deriv_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] len_r;
  logic [DEG_W-1:0] k_r;
  s64_t             x_r;
  s64_t             a_r;
  s64_t             b_r;
  s64_t             s_r;
  s64_t             dsq_r;
  s64_t             t_r;
  s64_t             fac1_r;
  s64_t             fac2_r;
  s64_t             den_r;
  s128_t            acc_r;
  s64_t             p1_r;
  s64_t             p2_r;
  logic             flag_r;
  s64_t             dv_r;
  logic             dv_flag_r;

  logic             out_valid_r;
  logic [DEG_W-1:0] out_degree_r;
  s64_t             out_value_r;
  logic             out_sat_r;
  logic             out_last_r;

  s64_t             a_cfg;
  s64_t             b_cfg;
  s64_t             a_ld;
  s64_t             b_ld;
  logic [CNT_W-1:0] cnt_ld;
  s64_t             nq;
  s64_t             cq;
  s64_t             mul_a;
  s64_t             mul_b;
  logic             mul_start;
  logic             mul_done;
  s128_t            mprod;
  logic             div_start;
  logic             div_done;
  s64_t             div_quo;
  logic             div_sat;
  logic             is_mul;
  logic             slot_free;
  logic             done;
  logic             k_last;
  logic [64:0]      sh24;
  logic [64:0]      sh30;
  logic [64:0]      sh25;
  logic [64:0]      shp1;

  always_comb begin
    a_cfg  = s64_t'(alpha_r);
    b_cfg  = s64_t'(beta_r);
    a_ld   = deriv_cfg_r ? a_cfg + ONE_Q24 : a_cfg;
    b_ld   = deriv_cfg_r ? b_cfg + ONE_Q24 : b_cfg;
    cnt_ld = (in_count > CNT_W'(MAX_ORDER)) ? CNT_W'(MAX_ORDER) : in_count;
    nq     = s64_t'({k_r, 24'd0});
    cq     = (nq <<< 1) + s_r;
    k_last = ({1'b0, k_r} == len_r - CNT_W'(1));
    slot_free = !out_valid_r || out_ready;
  end

  // operand selection, taken at the start of each multiply
  always_comb begin
    is_mul = 1'b1;
    mul_a  = a_r;
    mul_b  = a_r;
    case (cmd.op)
      OP_AA:  begin mul_a = a_r;                mul_b = a_r;                end
      OP_BB:  begin mul_a = b_r;                mul_b = b_r;                end
      OP_P1A: begin mul_a = x_r - ONE_Q30;      mul_b = s_r + TWO_Q24;      end
      OP_P1B: begin mul_a = a_r + ONE_Q24;      mul_b = TWO_Q30;            end
      OP_T1:  begin mul_a = cq;                 mul_b = cq - TWO_Q24;       end
      OP_T2:  begin mul_a = t_r;                mul_b = x_r;                end
      OP_F1:  begin mul_a = cq - ONE_Q24;       mul_b = t_r;                end
      OP_T3:  begin mul_a = nq + a_r - ONE_Q24; mul_b = nq + b_r - ONE_Q24; end
      OP_F2:  begin mul_a = t_r;                mul_b = cq;                 end
      OP_D1:  begin mul_a = s64_t'({k_r, 1'b0}); mul_b = nq + s_r;          end
      OP_D2:  begin mul_a = t_r;                mul_b = cq - TWO_Q24;       end
      OP_N1:  begin mul_a = fac1_r;             mul_b = p1_r;               end
      OP_N2:  begin mul_a = fac2_r;             mul_b = p2_r;               end
      OP_DV:  begin mul_a = s_r + nq;           mul_b = p1_r;               end
      default: is_mul = 1'b0;
    endcase
    mul_start = cmd.start && is_mul;
    div_start = cmd.start && (cmd.op == OP_DIV);
  end

  always_comb begin
    done = 1'b0;
    if (busy_r) begin
      case (op_r)
        OP_DIV: done = div_done;
        OP_EMIT_Z, OP_EMIT_Q, OP_EMIT_D: done = slot_free;
        OP_Q0, OP_P1C, OP_INC: done = 1'b1;
        default: done = mul_done;
      endcase
    end
    sh24 = shr_rnd_sat(mprod, 24);
    sh30 = shr_rnd_sat(mprod, 30);
    sh25 = shr_rnd_sat(mprod, 25);
    shp1 = shr_rnd_sat(acc_r, P1_SH);
  end

  jps_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mprod)
  );

  jps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo),
    .sat   (div_sat)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r     <= '0;
      beta_r      <= '0;
      deriv_cfg_r <= 1'b0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_ALPHA: alpha_r     <= cfg_wdata;
          REG_BETA:  beta_r      <= cfg_wdata;
          REG_DERIV: deriv_cfg_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.start) begin
        busy_r <= 1'b1;
      end else if (done) begin
        busy_r <= 1'b0;
      end
      if (busy_r && slot_free &&
          (op_r == OP_EMIT_Z || op_r == OP_EMIT_Q || op_r == OP_EMIT_D)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // run registers and writeback
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r <= cmd.op;
    end
    if (cmd.load) begin
      x_r     <= s64_t'(in_point);
      a_r     <= a_ld;
      b_r     <= b_ld;
      s_r     <= a_ld + b_ld;
      deriv_r <= deriv_cfg_r;
      cnt_r   <= cnt_ld;
      len_r   <= deriv_cfg_r ? cnt_ld - CNT_W'(1) : cnt_ld;
      k_r     <= '0;
    end
    if (done) begin
      case (op_r)
        OP_AA:  dsq_r <= sh24[63:0];
        OP_BB:  dsq_r <= dsq_r - sh24[63:0];
        OP_P1A: acc_r <= mprod;
        OP_P1B: acc_r <= acc_r + mprod;
        OP_P1C: begin
          p2_r   <= p1_r;
          p1_r   <= shp1[63:0];
          flag_r <= shp1[64];
        end
        OP_T1:  t_r    <= sh24[63:0];
        OP_T2:  t_r    <= sh30[63:0] + dsq_r;
        OP_F1:  fac1_r <= sh24[63:0];
        OP_T3:  t_r    <= sh24[63:0];
        OP_F2:  fac2_r <= -(s64_t'(sh24[63:0]) <<< 1);
        OP_D1:  t_r    <= mprod[63:0];
        OP_D2:  den_r  <= sh24[63:0];
        OP_N1:  acc_r  <= mprod;
        OP_N2:  acc_r  <= acc_r + mprod;
        OP_DIV: begin
          p2_r   <= p1_r;
          p1_r   <= div_quo;
          flag_r <= flag_r | div_sat;
        end
        OP_Q0: begin
          p1_r   <= Q0_VAL;
          flag_r <= 1'b0;
        end
        OP_DV: begin
          dv_r      <= sh25[63:0];
          dv_flag_r <= flag_r | sh25[64];
        end
        OP_EMIT_Z: begin
          out_degree_r <= '0;
          out_value_r  <= '0;
          out_sat_r    <= 1'b0;
          out_last_r   <= (cnt_r == CNT_W'(1));
        end
        OP_EMIT_Q: begin
          out_degree_r <= k_r;
          out_value_r  <= p1_r;
          out_sat_r    <= flag_r;
          out_last_r   <= k_last;
        end
        OP_EMIT_D: begin
          out_degree_r <= k_r + DEG_W'(1);
          out_value_r  <= dv_r;
          out_sat_r    <= dv_flag_r;
          out_last_r   <= k_last;
        end
        OP_INC: k_r <= k_r + DEG_W'(1);
        default: ;
      endcase
    end
  end

  always_comb begin
    sts.done     = done;
    sts.deriv    = deriv_r;
    sts.cnt_zero = (cnt_r == '0);
    sts.cnt_one  = (cnt_r == CNT_W'(1));
    sts.k_last   = k_last;
    sts.k_zero   = (k_r == '0);
  end

  assign out_valid     = out_valid_r;
  assign out_degree    = out_degree_r;
  assign out_value     = out_value_r;
  assign out_saturated = out_sat_r;
  assign out_last      = out_last_r;

endmodule

// ----- src/jps_ctrl.sv -----
// ----------------------------------------------------------------------------
// jps_ctrl: sequencing controller
// Walks the per-degree operation sequence and issues one datapath
// operation at a time, waiting for its completion.
// ----------------------------------------------------------------------------
module jps_ctrl import jps_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CHK  = 5'd1;
  localparam logic [4:0] S_AA   = 5'd2;
  localparam logic [4:0] S_BB   = 5'd3;
  localparam logic [4:0] S_EZ   = 5'd4;
  localparam logic [4:0] S_Q0   = 5'd5;
  localparam logic [4:0] S_OUT  = 5'd6;
  localparam logic [4:0] S_DV   = 5'd7;
  localparam logic [4:0] S_ED   = 5'd8;
  localparam logic [4:0] S_EQ   = 5'd9;
  localparam logic [4:0] S_INC  = 5'd10;
  localparam logic [4:0] S_P1A  = 5'd11;
  localparam logic [4:0] S_P1B  = 5'd12;
  localparam logic [4:0] S_P1C  = 5'd13;
  localparam logic [4:0] S_T1   = 5'd14;
  localparam logic [4:0] S_T2   = 5'd15;
  localparam logic [4:0] S_F1   = 5'd16;
  localparam logic [4:0] S_T3   = 5'd17;
  localparam logic [4:0] S_F2   = 5'd18;
  localparam logic [4:0] S_D1   = 5'd19;
  localparam logic [4:0] S_D2   = 5'd20;
  localparam logic [4:0] S_N1   = 5'd21;
  localparam logic [4:0] S_N2   = 5'd22;
  localparam logic [4:0] S_DIV  = 5'd23;

  logic [4:0] state_r;
  logic [4:0] state_nxt;
  logic       pend_r;
  logic       pend_nxt;
  logic       has_op;
  op_t        op;
  logic [4:0] after;

  // operation and successor of each working state
  always_comb begin
    has_op = 1'b1;
    op     = OP_Q0;
    after  = S_IDLE;
    case (state_r)
      S_AA:  begin op = OP_AA;  after = S_BB; end
      S_BB:  begin op = OP_BB;  after = sts.deriv ? S_EZ : S_Q0; end
      S_EZ:  begin op = OP_EMIT_Z; after = sts.cnt_one ? S_IDLE : S_Q0; end
      S_Q0:  begin op = OP_Q0;  after = S_OUT; end
      S_DV:  begin op = OP_DV;  after = S_ED; end
      S_ED:  begin op = OP_EMIT_D; after = sts.k_last ? S_IDLE : S_INC; end
      S_EQ:  begin op = OP_EMIT_Q; after = sts.k_last ? S_IDLE : S_INC; end
      S_INC: begin op = OP_INC; after = sts.k_zero ? S_P1A : S_T1; end
      S_P1A: begin op = OP_P1A; after = S_P1B; end
      S_P1B: begin op = OP_P1B; after = S_P1C; end
      S_P1C: begin op = OP_P1C; after = S_OUT; end
      S_T1:  begin op = OP_T1;  after = S_T2; end
      S_T2:  begin op = OP_T2;  after = S_F1; end
      S_F1:  begin op = OP_F1;  after = S_T3; end
      S_T3:  begin op = OP_T3;  after = S_F2; end
      S_F2:  begin op = OP_F2;  after = S_D1; end
      S_D1:  begin op = OP_D1;  after = S_D2; end
      S_D2:  begin op = OP_D2;  after = S_N1; end
      S_N1:  begin op = OP_N1;  after = S_N2; end
      S_N2:  begin op = OP_N2;  after = S_DIV; end
      S_DIV: begin op = OP_DIV; after = S_OUT; end
      default: has_op = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    in_ready  = (state_r == S_IDLE);
    cmd.load  = 1'b0;
    cmd.start = 1'b0;
    cmd.op    = op;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: state_nxt = sts.cnt_zero ? S_IDLE : S_AA;
      S_OUT: state_nxt = sts.deriv ? S_DV : S_EQ;
      default: begin
        if (has_op) begin
          if (!pend_r) begin
            cmd.start = 1'b1;
            pend_nxt  = 1'b1;
          end else if (sts.done) begin
            pend_nxt  = 1'b0;
            state_nxt = after;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

// ----- src/jacobi_polynomial_sequence_unit.sv -----
// ----------------------------------------------------------------------------
// jacobi_polynomial_sequence_unit: Jacobi polynomial sequence generator
// Emits P_0..P_(count-1) at a point x, or their first derivatives, for the
// configured alpha and beta using the three-term recurrence in fixed point.
// ----------------------------------------------------------------------------
// One input item is worked at a time; the input is ready only while the unit
// is idle. Each degree from two upward takes nine multiplies on the shared
// 64x64 multiplier (four 32x32 partial products each) plus a 128/64 divide
// at two quotient bits per cycle. A run lasts longer while the result side
// stalls, and derivative mode adds one multiply per degree. Results leave
// through an output register, and a held result stalls only the next emit.
// Configuration must be written while the unit is idle.
module jacobi_polynomial_sequence_unit import jps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  jps_in_if.sink               in_chan,
  jps_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  jps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  jps_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_point      (in_chan.point_q30),
    .in_count      (in_chan.degree_count),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .out_degree    (out_chan.degree),
    .out_value     (out_chan.value_q24),
    .out_saturated (out_chan.saturated),
    .out_last      (out_chan.last)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: Jacobi polynomial sequence unit
// Sends points and degree counts under several alpha/beta/mode settings,
// predicts every value in fixed point and checks each result transfer in
// order, with random idling on both channels and a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import jps_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;
  localparam int SETTLE      = 12000;

  typedef struct {
    logic [DEG_W-1:0] degree;
    s64_t             value;
    logic             sat;
    logic             last;
  } poly_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0]     cfg_wdata;

  jps_in_if  in_ch ();
  jps_out_if out_ch ();

  jacobi_polynomial_sequence_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch.sink),
    .out_chan (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // local copy of the configuration
  s64_t alpha_cur, beta_cur;
  logic deriv_cur;

  poly_result_t pending_values[$];
  int errors = 0;
  int cycles = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_cycles = 0;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stalls, or a counted hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // round half up, shift right, clip; bit 64 is the clip flag
  function automatic logic [64:0] round_clip(input s128_t v, input int sh);
    s128_t t, q;
    t = v + (s128_t'(1) <<< (sh - 1));
    q = t >>> sh;
    if (q[127:63] != {65{q[63]}}) return {1'b1, t[127] ? S64_MIN : S64_MAX};
    return {1'b0, q[63:0]};
  endfunction

  function automatic s128_t wide_mul(input s64_t a, input s64_t b);
    return s128_t'(a) * s128_t'(b);
  endfunction

  function automatic s64_t fx_mul(input s64_t a, input s64_t b, input int sh);
    logic [64:0] r;
    r = round_clip(wide_mul(a, b), sh);
    return r[63:0];
  endfunction

  // quotient rounded half away from zero, clipped; bit 64 is the clip flag
  function automatic logic [64:0] round_div(input s128_t num, input s64_t den);
    logic         neg;
    logic [127:0] un, ud, q, r, lim;
    if (den == 0) begin
      if (num == 0) return {1'b1, 64'd0};
      return {1'b1, num[127] ? S64_MIN : S64_MAX};
    end
    neg = num[127] ^ den[63];
    un  = num[127] ? -num : num;
    ud  = {64'd0, den[63] ? -den : den};
    q   = un / ud;
    r   = un % ud;
    if (r >= ud - r) q = q + 1;
    lim = neg ? (128'd1 << 63) : ((128'd1 << 63) - 1);
    if (q > lim) return {1'b1, neg ? S64_MIN : S64_MAX};
    return {1'b0, neg ? -q[63:0] : q[63:0]};
  endfunction

  // three-term recurrence, values with sticky clip flags
  task automatic recur_sequence(input s64_t x, input s64_t a, input s64_t b, input int cnt,
                                output s64_t p[MAX_ORDER], output logic fl[MAX_ORDER]);
    s64_t s, dsq, nq, c, inner, fac1, fac2, den;
    s128_t num;
    logic [64:0] r;
    s = a + b;
    dsq = fx_mul(a, a, 24) - fx_mul(b, b, 24);
    if (cnt < 1) return;
    p[0] = Q0_VAL;
    fl[0] = 1'b0;
    if (cnt < 2) return;
    r = round_clip(wide_mul(x - ONE_Q30, s + TWO_Q24) + wide_mul(a + ONE_Q24, TWO_Q30), P1_SH);
    p[1] = r[63:0];
    fl[1] = r[64];
    for (int n = 2; n < cnt; n++) begin
      nq = s64_t'(n) <<< 24;
      c = 2 * nq + s;
      inner = fx_mul(fx_mul(c, c - TWO_Q24, 24), x, 30) + dsq;
      fac1 = fx_mul(c - ONE_Q24, inner, 24);
      fac2 = -2 * fx_mul(fx_mul(nq + a - ONE_Q24, nq + b - ONE_Q24, 24), c, 24);
      den = fx_mul(s64_t'(2 * n) * (nq + s), c - TWO_Q24, 24);
      num = wide_mul(fac1, p[n-1]) + wide_mul(fac2, p[n-2]);
      r = round_div(num, den);
      p[n] = r[63:0];
      fl[n] = fl[n-1] | r[64];
    end
  endtask

  task automatic predict_values(input logic signed [31:0] pt, input logic [CNT_W-1:0] cnt_in);
    s64_t p[MAX_ORDER];
    logic fl[MAX_ORDER];
    int cnt;
    poly_result_t e;
    logic [64:0] r;
    cnt = (cnt_in > MAX_ORDER) ? MAX_ORDER : int'(cnt_in);
    if (deriv_cur && cnt > 1)
      recur_sequence(s64_t'(pt), alpha_cur + ONE_Q24, beta_cur + ONE_Q24, cnt - 1, p, fl);
    else if (!deriv_cur)
      recur_sequence(s64_t'(pt), alpha_cur, beta_cur, cnt, p, fl);
    for (int n = 0; n < cnt; n++) begin
      e.degree = n[DEG_W-1:0];
      e.last = (n == cnt - 1);
      if (!deriv_cur) begin
        e.value = p[n];
        e.sat = fl[n];
      end else if (n == 0) begin
        e.value = 0;
        e.sat = 1'b0;
      end else begin
        r = round_clip(wide_mul(alpha_cur + beta_cur + (s64_t'(n + 1) <<< 24), p[n-1]), 25);
        e.value = r[63:0];
        e.sat = fl[n-1] | r[64];
      end
      pending_values.push_back(e);
    end
  endtask

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    poly_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_values.size() == 0) begin
        $error("unexpected result degree %0d value %0d", out_ch.degree, out_ch.value_q24);
        errors++;
      end else begin
        e = pending_values.pop_front();
        if (out_ch.degree !== e.degree) begin
          $error("degree: expected %0d actual %0d", e.degree, out_ch.degree);
          errors++;
        end
        if (out_ch.value_q24 !== e.value) begin
          $error("value_q24: expected %0d actual %0d", e.value, out_ch.value_q24);
          errors++;
        end
        if (out_ch.saturated !== e.sat) begin
          $error("saturated: expected %0d actual %0d", e.sat, out_ch.saturated);
          errors++;
        end
        if (out_ch.last !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, out_ch.last);
          errors++;
        end
      end
    end
  end

  task automatic send_point(input logic signed [31:0] pt, input logic [CNT_W-1:0] cnt);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.point_q30 <= pt;
    in_ch.degree_count <= cnt;
    do @(posedge clk); while (!in_ch.ready);
    predict_values(pt, cnt);
  endtask

  // hold until every prediction has arrived, then let the block settle
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ALPHA) alpha_cur = s64_t'(signed'(val[CFG_W-1:0]));
    else if (idx == REG_BETA) beta_cur = s64_t'(signed'(val[CFG_W-1:0]));
    else if (idx == REG_DERIV) deriv_cur = val[0];
  endtask

  task automatic set_params(input int a, input int b, input logic d);
    write_reg(REG_ALPHA, a);
    write_reg(REG_BETA, b);
    write_reg(REG_DERIV, int'(d));
  endtask

  function automatic int rand_param();
    case ($urandom_range(0, 5))
      0: return -16777215;
      1: return 1073741823;
      2: return int'($urandom_range(0, 50331648)) - 16777215;
      default: return int'($urandom_range(0, 1090519038)) - 16777215;
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] rand_count();
    int k;
    k = $urandom_range(0, 99);
    if (k < 3) return '0;
    if (k < 6) return CNT_W'($urandom_range(65, 127));
    if (k < 12) return CNT_W'($urandom_range(9, 64));
    return CNT_W'($urandom_range(1, 8));
  endfunction

  function automatic logic [31:0] rand_point();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return int'($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
  endfunction

  task automatic test_directed();
    set_params(0, 0, 1'b0);
    send_point(32'sh4000_0000, 7'd5);
    send_point(32'sh7FFF_FFFF, 7'd3);
    send_point(32'sh8000_0000, 7'd3);
    send_point(32'sh0000_0000, 7'd1);
    send_point(32'shC000_0000, 7'd0);
    send_point(32'sh1234_5678, 7'd64);
    send_point(32'sh2000_0000, 7'd127);
    drain_results();
    // write to an unused index is dropped
    write_reg(2'd3, 32'h7FFF_FFFF);
    set_params(-16777215, 1073741823, 1'b1);
    send_point(32'sh2000_0000, 7'd1);
    send_point(32'shE000_0000, 7'd2);
    send_point(32'sh3000_0000, 7'd12);
    drain_results();
    // overflow path: large parameters and many degrees
    set_params(1073741823, 1073741823, 1'b0);
    send_point(32'sh7FFF_FFFF, 7'd20);
    send_point(32'sh8000_0000, 7'd20);
    drain_results();
    // parameters at minus one give a zero divisor
    set_params(-16777216, -16777216, 1'b0);
    send_point(32'sh1000_0000, 7'd4);
    send_point(32'sh0000_0000, 7'd4);
    drain_results();
    set_params(-1073741824, 16777216, 1'b1);
    send_point(32'shF000_0000, 7'd6);
    drain_results();
    set_params(-1073741824, -1073741824, 1'b0);
    send_point(32'sh4000_0000, 7'd6);
    drain_results();
  endtask

  task automatic test_random_phase(input int tx_pct, input int rx_pct, input int items);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    for (int i = 0; i < items; i++) begin
      if (i % 13 == 0) begin
        drain_results();
        set_params(rand_param(), rand_param(), 1'($urandom_range(0, 1)));
      end
      send_point(rand_point(), rand_count());
    end
    drain_results();
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    set_params(int'($urandom_range(0, 33554432)) - 16777215, 8388608, 1'b0);
    hold_cycles = 4000;
    for (int i = 0; i < 6; i++) send_point(rand_point(), CNT_W'($urandom_range(2, 8)));
    drain_results();
    send_point(rand_point(), 7'd4);
    drain_results();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.point_q30 = '0;
    in_ch.degree_count = '0;
    alpha_cur = 0;
    beta_cur = 0;
    deriv_cur = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phase(0, 0, 52);
    test_random_phase(68, 0, 52);
    test_random_phase(0, 68, 52);
    test_random_phase(34, 34, 52);
    test_backpressure();
    drain_results();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
